// ===== src/fvt_pkg.sv =====
// Frustum visibility test: shared types, field widths and helpers.
// Used by every design module of the block (not the checker); depends on nothing else.
package fvt_pkg;

  localparam int COORD_W         = 24;
  localparam int EXT_W           = 23;
  localparam int CORNER_W        = COORD_W + 1;
  localparam int COEF_W          = 14;
  localparam int D_W             = 22;
  localparam int PLANE_W         = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int RADIUS_SHIFT    = 12;
  localparam int D_BASE_SHIFT    = 4;
  localparam int PIPE_STAGES     = 5;
  localparam int PLANE_COUNT_DEF = 6;
  localparam int COORD_FRAC_DEF  = 8;

  // Plane word packing
  localparam int A_LSB = 0;
  localparam int B_LSB = 14;
  localparam int C_LSB = 28;
  localparam int D_LSB = 42;

  typedef enum logic [1:0] {
    FUNC_POINT       = 2'd0,
    FUNC_SPHERE      = 2'd1,
    FUNC_CUBE_CORNER = 2'd2,
    FUNC_CUBE_CENTER = 2'd3
  } func_t;

  typedef struct packed {
    func_t                     func;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [EXT_W-1:0]          ext;
  } query_t;

  typedef struct packed {
    logic signed [CORNER_W-1:0] x;
    logic signed [CORNER_W-1:0] y;
    logic signed [CORNER_W-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t             lo;
    vec_t             hi;
    logic             sphere;
    logic [EXT_W-1:0] ext;
  } corner_t;

  // Farthest corner along the plane normal: hi for a positive coefficient.
  function automatic logic signed [CORNER_W-1:0] pick_corner(
    input logic signed [COEF_W-1:0]   coef,
    input logic signed [CORNER_W-1:0] lo,
    input logic signed [CORNER_W-1:0] hi
  );
    logic pos;
    pos = !coef[COEF_W-1] && (coef != '0);
    return pos ? hi : lo;
  endfunction

endpackage

// ===== src/fvt_cfg_regs.sv =====
// Frustum visibility test: plane register file written through the config port.
// Depends on fvt_pkg.
module fvt_cfg_regs #(
  parameter int PLANE_COUNT = fvt_pkg::PLANE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fvt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fvt_pkg::PLANE_W-1:0]     cfg_wdata,
  output logic [fvt_pkg::PLANE_W-1:0]     plane_o [PLANE_COUNT]
);

  logic [fvt_pkg::PLANE_W-1:0] plane_r   [PLANE_COUNT];
  logic [fvt_pkg::PLANE_W-1:0] plane_nxt [PLANE_COUNT];

  // Indexes past the last plane match no entry and are dropped.
  always_comb begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      plane_nxt[i] = plane_r[i];
      if (cfg_we && (cfg_index == fvt_pkg::CFG_IDX_W'(i))) begin
        plane_nxt[i] = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      if (!rst_n) begin
        plane_r[i] <= '0;
      end else begin
        plane_r[i] <= plane_nxt[i];
      end
    end
  end

  assign plane_o = plane_r;

endmodule

// ===== src/fvt_corner.sv =====
// Frustum visibility test: corner stage, forms the low and high cube corners.
// Depends on fvt_pkg.
module fvt_corner (
  input  logic              clk,
  input  fvt_pkg::query_t   query_i,
  output fvt_pkg::corner_t  corner_o
);

  fvt_pkg::corner_t                   corner_nxt;
  fvt_pkg::corner_t                   corner_r;
  logic signed [fvt_pkg::CORNER_W-1:0] e_s;
  logic signed [fvt_pkg::CORNER_W-1:0] xs, ys, zs;
  logic                                is_cube, is_center;

  always_comb begin
    e_s       = $signed({2'b00, query_i.ext});
    xs        = fvt_pkg::CORNER_W'(query_i.x);
    ys        = fvt_pkg::CORNER_W'(query_i.y);
    zs        = fvt_pkg::CORNER_W'(query_i.z);
    is_center = (query_i.func == fvt_pkg::FUNC_CUBE_CENTER);
    is_cube   = is_center || (query_i.func == fvt_pkg::FUNC_CUBE_CORNER);

    corner_nxt.lo.x   = is_center ? xs - e_s : xs;
    corner_nxt.lo.y   = is_center ? ys - e_s : ys;
    corner_nxt.lo.z   = is_center ? zs - e_s : zs;
    corner_nxt.hi.x   = is_cube ? xs + e_s : xs;
    corner_nxt.hi.y   = is_cube ? ys + e_s : ys;
    corner_nxt.hi.z   = is_cube ? zs + e_s : zs;
    corner_nxt.sphere = (query_i.func == fvt_pkg::FUNC_SPHERE);
    corner_nxt.ext    = query_i.ext;
  end

  always_ff @(posedge clk) begin
    corner_r <= corner_nxt;
  end

  assign corner_o = corner_r;

endmodule

// ===== src/fvt_plane_eval.sv =====
// Frustum visibility test: one plane lane, three stages (multiply, partial
// sums, final add and sign test). Depends on fvt_pkg.
module fvt_plane_eval #(
  parameter int COORD_FRAC_BITS = fvt_pkg::COORD_FRAC_DEF
) (
  input  logic                        clk,
  input  logic [fvt_pkg::PLANE_W-1:0] plane_i,
  input  fvt_pkg::corner_t            corner_i,
  output logic                        pass_o
);

  localparam int PROD_W = fvt_pkg::COEF_W + fvt_pkg::CORNER_W;
  localparam int DSH    = fvt_pkg::D_BASE_SHIFT + COORD_FRAC_BITS;
  localparam int DT_W   = fvt_pkg::D_W + DSH;
  localparam int BIAS_W = fvt_pkg::EXT_W + fvt_pkg::RADIUS_SHIFT + 1;
  localparam int M1_W   = (PROD_W > DT_W) ? PROD_W : DT_W;
  localparam int M2_W   = (M1_W > BIAS_W) ? M1_W : BIAS_W;
  localparam int SUM_W  = M2_W + 3;

  logic signed [fvt_pkg::COEF_W-1:0]   coef_a, coef_b, coef_c;
  logic signed [fvt_pkg::D_W-1:0]      coef_d;
  logic signed [fvt_pkg::CORNER_W-1:0] px, py, pz;
  logic signed [SUM_W-1:0]             d_term, bias;

  logic signed [PROD_W-1:0] prod_a_r, prod_b_r, prod_c_r;
  logic signed [SUM_W-1:0]  const_r;
  logic signed [SUM_W-1:0]  part_ab_r, part_c_r;
  logic signed [SUM_W-1:0]  total;
  logic                     pass_r;

  always_comb begin
    coef_a = plane_i[fvt_pkg::A_LSB +: fvt_pkg::COEF_W];
    coef_b = plane_i[fvt_pkg::B_LSB +: fvt_pkg::COEF_W];
    coef_c = plane_i[fvt_pkg::C_LSB +: fvt_pkg::COEF_W];
    coef_d = plane_i[fvt_pkg::D_LSB +: fvt_pkg::D_W];
    // The corner farthest along the normal decides for the whole cube.
    px     = fvt_pkg::pick_corner(coef_a, corner_i.lo.x, corner_i.hi.x);
    py     = fvt_pkg::pick_corner(coef_b, corner_i.lo.y, corner_i.hi.y);
    pz     = fvt_pkg::pick_corner(coef_c, corner_i.lo.z, corner_i.hi.z);
    d_term = SUM_W'(coef_d) <<< DSH;
    // Sphere test dist > -r folds into dist + r > 0.
    bias   = corner_i.sphere
             ? (SUM_W'($signed({1'b0, corner_i.ext})) <<< fvt_pkg::RADIUS_SHIFT)
             : '0;
  end

  always_ff @(posedge clk) begin
    prod_a_r <= PROD_W'(coef_a) * PROD_W'(px);
    prod_b_r <= PROD_W'(coef_b) * PROD_W'(py);
    prod_c_r <= PROD_W'(coef_c) * PROD_W'(pz);
    const_r  <= d_term + bias;
  end

  always_ff @(posedge clk) begin
    part_ab_r <= SUM_W'(prod_a_r) + SUM_W'(prod_b_r);
    part_c_r  <= SUM_W'(prod_c_r) + const_r;
  end

  assign total = part_ab_r + part_c_r;

  always_ff @(posedge clk) begin
    pass_r <= !total[SUM_W-1] && (total != '0);
  end

  assign pass_o = pass_r;

endmodule

// ===== src/frustum_visibility_test_unit.sv =====
// Frustum visibility test: top level with input register, plane lanes and
// the visibility reduction. Depends on fvt_pkg, fvt_cfg_regs, fvt_corner, fvt_plane_eval.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  query    | start / busy       | in_func, in_x_pos, in_y_pos, in_z_pos, in_extent
//  result   | out_strobe         | out_visible
//  config   | cfg_we, cfg_index  | cfg_wdata (one 64-bit plane word)
//
// One query can be taken every cycle; busy stays low.
// A taken query passes the input register, corner stage, multiply, partial
// sums, final add and sign test, and output register before its result appears.
// Each plane has its own lane of three 14x25 multipliers, so throughput is set
// only by that pipeline. Reset clears the valid bits and the plane registers
// (all planes zero). The receiver cannot stall, so no stage ever holds.
module frustum_visibility_test_unit #(
  parameter int PLANE_COUNT     = fvt_pkg::PLANE_COUNT_DEF,
  parameter int COORD_FRAC_BITS = fvt_pkg::COORD_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_func,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_x_pos,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_y_pos,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_z_pos,
  input  logic [fvt_pkg::EXT_W-1:0]           in_extent,
  output logic                                out_strobe,
  output logic                                out_visible,
  input  logic                                cfg_we,
  input  logic [fvt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fvt_pkg::PLANE_W-1:0]         cfg_wdata
);

  logic [fvt_pkg::PLANE_W-1:0]     plane [PLANE_COUNT];
  fvt_pkg::query_t                 query_r;
  fvt_pkg::corner_t                corner;
  logic [fvt_pkg::PIPE_STAGES-1:0] valid_r, valid_nxt;
  logic [PLANE_COUNT-1:0]          pass;
  logic                            accept;
  logic                            out_strobe_r, out_visible_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      query_r.func <= fvt_pkg::func_t'(in_func);
      query_r.x    <= in_x_pos;
      query_r.y    <= in_y_pos;
      query_r.z    <= in_z_pos;
      query_r.ext  <= in_extent;
    end
  end

  // Valid bits advance one stage per cycle alongside the data.
  assign valid_nxt = {valid_r[fvt_pkg::PIPE_STAGES-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      out_strobe_r <= valid_r[fvt_pkg::PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    out_visible_r <= &pass;
  end

  assign out_strobe  = out_strobe_r;
  assign out_visible = out_visible_r;

  fvt_cfg_regs #(
    .PLANE_COUNT(PLANE_COUNT)
  ) u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .plane_o  (plane)
  );

  fvt_corner u_corner (
    .clk     (clk),
    .query_i (query_r),
    .corner_o(corner)
  );

  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_lane
    fvt_plane_eval #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_plane_eval (
      .clk     (clk),
      .plane_i (plane[g]),
      .corner_i(corner),
      .pass_o  (pass[g])
    );
  end

endmodule

// ===== src/fvt_checker.sv =====
// Frustum visibility test: port-level checker and its bind to the top level.
// Depends on frustum_visibility_test_unit.
module fvt_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  // Every taken query yields exactly one result on out_strobe.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_strobe)
    else $error("query taken without a result six cycles later");

  a_result_has_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 6))
    else $error("result without a matching query");

  a_reset_flushes: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

endmodule

bind frustum_visibility_test_unit fvt_checker u_fvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_strobe(out_strobe)
);
